// ===== rtl/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// Types and constants shared by the I2C register access master.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned ADDR_W     = 7;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SLOT_W     = 8;
	localparam int unsigned REC_W      = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY   = 1'd1;

	localparam logic [SLOT_W-1:0] SLOT_TICKS_RST = 8'd1;
	localparam logic [REC_W-1:0]  RECOVERY_RST   = 16'd5000;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUS_BUSY = 2'd1,
		ST_NO_START = 2'd2,
		ST_NO_ACK   = 2'd3
	} stat_t;

	// sequence segments, each split into up to four sub-slots
	typedef enum logic [3:0] {
		SEG_IDLE      = 4'd0,
		SEG_START1    = 4'd1,
		SEG_ADDR_W    = 4'd2,
		SEG_ACK_ADDR  = 4'd3,
		SEG_REG       = 4'd4,
		SEG_ACK_REG   = 4'd5,
		SEG_DATA      = 4'd6,
		SEG_ACK_DATA  = 4'd7,
		SEG_START2    = 4'd8,
		SEG_ADDR_R    = 4'd9,
		SEG_ACK_ADDRR = 4'd10,
		SEG_READ      = 4'd11,
		SEG_NACK      = 4'd12,
		SEG_STOP      = 4'd13,
		SEG_STOP_ABT  = 4'd14,
		SEG_RECOVERY  = 4'd15
	} seg_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] target_address;
		logic [BYTE_W-1:0] register_index;
		logic [BYTE_W-1:0] write_data;
		logic              sda_in;
	} ira_cmd_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		stat_t             status;
		logic [BYTE_W-1:0] rd;
	} ira_res_t;

	typedef struct packed {
		seg_t              seg;
		logic [1:0]        sub;
		logic [2:0]        bit_cnt;
		logic [BYTE_W-1:0] shift;
		logic [SLOT_W-1:0] slot_cnt;
		logic [REC_W-1:0]  rec_cnt;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] reg_idx;
		logic [BYTE_W-1:0] data;
		logic              is_read;
		logic              scl;
		logic              sda;
	} ira_state_t;

	localparam ira_state_t STATE_RST = '{
		seg:      SEG_IDLE,
		sub:      2'd0,
		bit_cnt:  3'd0,
		shift:    8'd0,
		slot_cnt: 8'd0,
		rec_cnt:  16'd0,
		addr:     7'd0,
		reg_idx:  8'd0,
		data:     8'd0,
		is_read:  1'b0,
		scl:      1'b1,
		sda:      1'b1
	};

endpackage

// ===== rtl/ira_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ira_cmd_if
// Request channel: command or tick with the sampled SDA level.
// ----------------------------------------------------------------------------
interface ira_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [ira_pkg::OP_W-1:0]     operation;
	logic [ira_pkg::ADDR_W-1:0]   target_address;
	logic [ira_pkg::BYTE_W-1:0]   register_index;
	logic [ira_pkg::BYTE_W-1:0]   write_data;
	logic                         sda_in;

	modport source (
		output valid, operation, target_address, register_index, write_data, sda_in,
		input  ready
	);
	modport sink (
		input  valid, operation, target_address, register_index, write_data, sda_in,
		output ready
	);
endinterface

// ===== rtl/ira_res_if.sv =====
// ----------------------------------------------------------------------------
// ira_res_if
// Result channel: pin levels, busy/done flags, status and read byte.
// ----------------------------------------------------------------------------
interface ira_res_if;
	logic                       valid;
	logic                       ready;
	logic                       scl_release;
	logic                       sda_release;
	logic                       busy_res;
	logic                       done_res;
	logic [1:0]                 status;
	logic [ira_pkg::BYTE_W-1:0] read_data;

	modport source (
		output valid, scl_release, sda_release, busy_res, done_res, status, read_data,
		input  ready
	);
	modport sink (
		input  valid, scl_release, sda_release, busy_res, done_res, status, read_data,
		output ready
	);
endinterface

// ===== rtl/ira_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ira_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ira_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ira_pkg::CFG_IDX_W-1:0]  index;
	logic [ira_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== rtl/ira_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ira_cfg_regs
// Slot length and write recovery registers.
// ----------------------------------------------------------------------------
module ira_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	ira_cfg_if.sink                      cfg,
	output logic [ira_pkg::SLOT_W-1:0]   slot_ticks,
	output logic [ira_pkg::REC_W-1:0]    recovery_ticks
);

	logic [ira_pkg::SLOT_W-1:0] slot_ticks_q;
	logic [ira_pkg::REC_W-1:0]  recovery_ticks_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ticks_q     <= ira_pkg::SLOT_TICKS_RST;
			recovery_ticks_q <= ira_pkg::RECOVERY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ira_pkg::REG_SLOT_TICKS: begin
					slot_ticks_q <= cfg.data[ira_pkg::SLOT_W-1:0];
				end
				ira_pkg::REG_RECOVERY: begin
					recovery_ticks_q <= cfg.data[ira_pkg::REC_W-1:0];
				end
				default: begin
					slot_ticks_q <= slot_ticks_q;
				end
			endcase
		end
	end

	assign slot_ticks     = slot_ticks_q;
	assign recovery_ticks = recovery_ticks_q;

endmodule

// ===== rtl/ira_seq.sv =====
// ----------------------------------------------------------------------------
// ira_seq
// Bit sequencer: state registers and the one-step next-state logic.
// ----------------------------------------------------------------------------
module ira_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  ira_pkg::ira_cmd_t          cmd,
	input  logic [ira_pkg::SLOT_W-1:0] slot_ticks,
	input  logic [ira_pkg::REC_W-1:0]  recovery_ticks,
	output ira_pkg::ira_res_t          res
);

	ira_pkg::ira_state_t st_q;
	ira_pkg::ira_state_t nx;
	logic                done;
	ira_pkg::stat_t      stat;
	logic [ira_pkg::BYTE_W-1:0] rd;
	logic [ira_pkg::SLOT_W-1:0] lim;
	logic [ira_pkg::SLOT_W:0]   cnt;

	// pin levels for the current segment and sub-slot
	function automatic ira_pkg::ira_state_t drive(input ira_pkg::ira_state_t s);
		ira_pkg::ira_state_t r;
		r = s;
		case (s.seg)
			ira_pkg::SEG_START1, ira_pkg::SEG_START2: begin
				r.scl = 1'b1;
				r.sda = (s.sub == 2'd0);
			end
			ira_pkg::SEG_ADDR_W, ira_pkg::SEG_REG, ira_pkg::SEG_DATA,
			ira_pkg::SEG_ADDR_R: begin
				r.scl = (s.sub == 2'd2);
				if (s.sub == 2'd1) r.sda = s.shift[ira_pkg::BYTE_W-1];
			end
			ira_pkg::SEG_ACK_ADDR, ira_pkg::SEG_ACK_REG, ira_pkg::SEG_ACK_DATA,
			ira_pkg::SEG_ACK_ADDRR: begin
				r.scl = (s.sub == 2'd2);
				if (s.sub == 2'd1 || s.sub == 2'd2) r.sda = 1'b1;
			end
			ira_pkg::SEG_READ: begin
				r.sda = 1'b1;
				r.scl = (s.sub == 2'd1);
			end
			ira_pkg::SEG_NACK: begin
				r.scl = (s.sub == 2'd2);
				if (s.sub != 2'd0) r.sda = 1'b1;
			end
			ira_pkg::SEG_STOP, ira_pkg::SEG_STOP_ABT: begin
				r.scl = (s.sub >= 2'd2);
				if (s.sub == 2'd1) r.sda = 1'b0;
				if (s.sub == 2'd3) r.sda = 1'b1;
			end
			default: begin
				r.scl = 1'b1;
				r.sda = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic ira_pkg::ira_state_t enter(input ira_pkg::ira_state_t s,
			input ira_pkg::seg_t seg);
		ira_pkg::ira_state_t r;
		r = s;
		r.seg     = seg;
		r.sub     = 2'd0;
		r.bit_cnt = 3'd0;
		case (seg)
			ira_pkg::SEG_ADDR_W: r.shift = {s.addr, 1'b0};
			ira_pkg::SEG_REG:    r.shift = s.reg_idx;
			ira_pkg::SEG_DATA:   r.shift = s.data;
			ira_pkg::SEG_ADDR_R: r.shift = {s.addr, 1'b1};
			ira_pkg::SEG_READ:   r.shift = '0;
			default:             r.shift = s.shift;
		endcase
		return drive(r);
	endfunction

	function automatic ira_pkg::ira_state_t next_sub(input ira_pkg::ira_state_t s);
		ira_pkg::ira_state_t r;
		r = s;
		r.sub = s.sub + 2'd1;
		return drive(r);
	endfunction

	always_comb begin
		nx   = st_q;
		done = 1'b0;
		stat = ira_pkg::ST_OK;
		rd   = '0;
		lim  = (slot_ticks == '0) ? ira_pkg::SLOT_W'(1) : slot_ticks;
		cnt  = {1'b0, st_q.slot_cnt} + (ira_pkg::SLOT_W + 1)'(1);

		if (st_q.seg == ira_pkg::SEG_IDLE) begin
			if (cmd.operation == ira_pkg::OP_WRITE || cmd.operation == ira_pkg::OP_READ) begin
				nx.addr     = cmd.target_address;
				nx.reg_idx  = cmd.register_index;
				nx.data     = cmd.write_data;
				nx.is_read  = (cmd.operation == ira_pkg::OP_READ);
				nx.slot_cnt = '0;
				nx          = enter(nx, ira_pkg::SEG_START1);
			end
		end else if (cmd.operation == ira_pkg::OP_TICK) begin
			if (st_q.seg == ira_pkg::SEG_RECOVERY) begin
				nx.rec_cnt = st_q.rec_cnt - ira_pkg::REC_W'(1);
				if (nx.rec_cnt == '0) done = 1'b1;
			end else if (cnt < {1'b0, lim}) begin
				nx.slot_cnt = cnt[ira_pkg::SLOT_W-1:0];
			end else begin
				nx.slot_cnt = '0;
				// end of slot: sample SDA and advance
				case (st_q.seg)
					ira_pkg::SEG_START1, ira_pkg::SEG_START2: begin
						if (st_q.seg == ira_pkg::SEG_START1 && st_q.sub == 2'd0 && !cmd.sda_in) begin
							done = 1'b1;
							stat = ira_pkg::ST_BUS_BUSY;
						end else if (st_q.seg == ira_pkg::SEG_START1 && st_q.sub == 2'd1
								&& cmd.sda_in) begin
							done = 1'b1;
							stat = ira_pkg::ST_NO_START;
						end else if (st_q.sub >= 2'd2) begin
							nx = enter(nx, (st_q.seg == ira_pkg::SEG_START1) ?
								ira_pkg::SEG_ADDR_W : ira_pkg::SEG_ADDR_R);
						end else begin
							nx = next_sub(nx);
						end
					end
					ira_pkg::SEG_ADDR_W, ira_pkg::SEG_REG, ira_pkg::SEG_DATA,
					ira_pkg::SEG_ADDR_R: begin
						if (st_q.sub < 2'd2) begin
							nx = next_sub(nx);
						end else begin
							nx.shift = {st_q.shift[ira_pkg::BYTE_W-2:0], 1'b0};
							if (st_q.bit_cnt == 3'd7) begin
								nx = enter(nx, ira_pkg::seg_t'(st_q.seg + 4'd1));
							end else begin
								nx.bit_cnt = st_q.bit_cnt + 3'd1;
								nx.sub     = 2'd0;
								nx         = drive(nx);
							end
						end
					end
					ira_pkg::SEG_ACK_ADDR, ira_pkg::SEG_ACK_REG, ira_pkg::SEG_ACK_DATA,
					ira_pkg::SEG_ACK_ADDRR: begin
						if (st_q.sub == 2'd2) begin
							// address ack is remembered in the bit counter
							if (st_q.seg == ira_pkg::SEG_ACK_ADDR) nx.bit_cnt = {2'b00, cmd.sda_in};
							nx = next_sub(nx);
						end else if (st_q.sub < 2'd3) begin
							nx = next_sub(nx);
						end else if (st_q.seg == ira_pkg::SEG_ACK_ADDR) begin
							nx = enter(nx, (st_q.bit_cnt != 3'd0) ?
								ira_pkg::SEG_STOP_ABT : ira_pkg::SEG_REG);
						end else if (st_q.seg == ira_pkg::SEG_ACK_REG) begin
							nx = enter(nx, st_q.is_read ? ira_pkg::SEG_START2 : ira_pkg::SEG_DATA);
						end else if (st_q.seg == ira_pkg::SEG_ACK_DATA) begin
							nx = enter(nx, ira_pkg::SEG_STOP);
						end else begin
							nx = enter(nx, ira_pkg::SEG_READ);
						end
					end
					ira_pkg::SEG_READ: begin
						if (st_q.sub == 2'd0) begin
							nx = next_sub(nx);
						end else begin
							nx.shift = {st_q.shift[ira_pkg::BYTE_W-2:0], cmd.sda_in};
							if (st_q.bit_cnt == 3'd7) begin
								nx = enter(nx, ira_pkg::SEG_NACK);
							end else begin
								nx.bit_cnt = st_q.bit_cnt + 3'd1;
								nx.sub     = 2'd0;
								nx         = drive(nx);
							end
						end
					end
					ira_pkg::SEG_NACK: begin
						if (st_q.sub < 2'd3) nx = next_sub(nx);
						else nx = enter(nx, ira_pkg::SEG_STOP);
					end
					ira_pkg::SEG_STOP: begin
						if (st_q.sub < 2'd3) begin
							nx = next_sub(nx);
						end else if (!st_q.is_read && recovery_ticks != '0) begin
							nx.rec_cnt = recovery_ticks;
							nx         = enter(nx, ira_pkg::SEG_RECOVERY);
						end else begin
							done = 1'b1;
						end
					end
					ira_pkg::SEG_STOP_ABT: begin
						if (st_q.sub < 2'd3) begin
							nx = next_sub(nx);
						end else begin
							done = 1'b1;
							stat = ira_pkg::ST_NO_ACK;
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end

			if (done) begin
				if (stat == ira_pkg::ST_OK && nx.is_read) rd = nx.shift;
				nx.seg      = ira_pkg::SEG_IDLE;
				nx.sub      = 2'd0;
				nx.bit_cnt  = '0;
				nx.slot_cnt = '0;
				nx.rec_cnt  = '0;
				nx.scl      = 1'b1;
				nx.sda      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ira_pkg::STATE_RST;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	assign res.scl    = nx.scl;
	assign res.sda    = nx.sda;
	assign res.busy   = (nx.seg != ira_pkg::SEG_IDLE);
	assign res.done   = done;
	assign res.status = stat;
	assign res.rd     = rd;

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seg == ira_pkg::SEG_IDLE |-> st_q.scl && st_q.sda && st_q.sub == 2'd0)
		else $error("idle sequencer does not release the bus");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && done |=> st_q.seg == ira_pkg::SEG_IDLE)
		else $error("sequencer not idle after done");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res.status != ira_pkg::ST_OK |-> res.done && res.rd == '0)
		else $error("error status without done or with read data");

	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_q.seg == ira_pkg::SEG_IDLE |=>
			st_q.seg == ira_pkg::SEG_IDLE || st_q.seg == ira_pkg::SEG_START1)
		else $error("idle sequencer left for a segment other than the first start");

endmodule

// ===== rtl/i2c_register_access_master_top.sv =====
// a request accepted into the input stage has its result registered in the result
// register when that stage next advances (result register free or being drained)
// throughput: one request per clock while the result side does not stall; the
// sequencer makes one step per request
// reset: arst_n clears the sequencer to idle with both lines released, empties both
// pipeline stages and loads slot_ticks = 1, recovery_ticks = 5000
// ----------------------------------------------------------------------------
// i2c_register_access_master_top
// Open-drain I2C master for single-register writes and reads, stepped by ticks.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top (
	input  logic     clk,
	input  logic     arst_n,
	ira_cmd_if.sink  cmd,
	ira_res_if.source res,
	ira_cfg_if.sink  cfg
);

	logic                       valid_s1;
	ira_pkg::ira_cmd_t          cmd_s1;
	logic                       out_valid_q;
	ira_pkg::ira_res_t          res_q;
	ira_pkg::ira_res_t          res_nx;
	logic                       adv;
	logic                       accept;
	logic [ira_pkg::SLOT_W-1:0] slot_ticks;
	logic [ira_pkg::REC_W-1:0]  recovery_ticks;

	ira_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.slot_ticks     (slot_ticks),
		.recovery_ticks (recovery_ticks)
	);

	ira_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (adv),
		.cmd            (cmd_s1),
		.slot_ticks     (slot_ticks),
		.recovery_ticks (recovery_ticks),
		.res            (res_nx)
	);

	// input stage moves on whenever the result register is free or being drained
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.operation      <= cmd.operation;
			cmd_s1.target_address <= cmd.target_address;
			cmd_s1.register_index <= cmd.register_index;
			cmd_s1.write_data     <= cmd.write_data;
			cmd_s1.sda_in         <= cmd.sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.scl_release = res_q.scl;
	assign res.sda_release = res_q.sda;
	assign res.busy_res    = res_q.busy;
	assign res.done_res    = res_q.done;
	assign res.status      = res_q.status;
	assign res.read_data   = res_q.rd;

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after stage advance");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cmd.ready)
		else $error("empty input stage refuses requests");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !res.ready |-> !cmd.ready && !adv)
		else $error("request taken while both stages are stalled");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register access master. A directed table
// opens the run, then random write and read transfers are clocked out against
// a cycle-free model of the bit sequencer, with an answering device on SDA
// that can refuse the bus, drop the start or leave the address unanswered.
// Both channels idle at random between requests.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ira_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic [1:0] {
		FLT_NONE,
		FLT_BUS_BUSY,
		FLT_NO_START,
		FLT_NO_ACK
	} fault_t;

	typedef struct packed {
		ira_cmd_t req;
		logic     typed;
		ira_res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ira_cmd_if cmd_ch ();
	ira_res_if res_ch ();
	ira_cfg_if cfg_ch ();

	i2c_register_access_master_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// bus sequencer model
	seg_t              sq_seg;
	logic [1:0]        sq_sub;
	logic [2:0]        sq_bit;
	logic [BYTE_W-1:0] sq_shift;
	logic [SLOT_W-1:0] sq_slot_cnt;
	logic [REC_W-1:0]  sq_rec;
	logic [ADDR_W-1:0] sq_addr;
	logic [BYTE_W-1:0] sq_reg;
	logic [BYTE_W-1:0] sq_data;
	logic              sq_is_read;
	logic              sq_scl;
	logic              sq_sda;
	logic [SLOT_W-1:0] cfg_slot;
	logic [REC_W-1:0]  cfg_rec;

	ira_res_t bus_expect_q [$];
	dir_row_t dir_rows [$];

	bit cmd_idle;
	bit res_idle;
	int res_gap;
	int quiet_cycles;
	int errors;
	int n_checked;
	int steps_taken;
	int n_writes;
	int n_reads;
	int n_aborts;

	always #1 clk = ~clk;

	function automatic void update_pins();
		case (sq_seg)
			SEG_START1, SEG_START2: begin
				sq_scl = 1'b1;
				sq_sda = (sq_sub == 2'd0);
			end
			SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R: begin
				sq_scl = (sq_sub == 2'd2);
				if (sq_sub == 2'd1) sq_sda = sq_shift[BYTE_W-1];
			end
			SEG_ACK_ADDR, SEG_ACK_REG, SEG_ACK_DATA, SEG_ACK_ADDRR: begin
				sq_scl = (sq_sub == 2'd2);
				if (sq_sub == 2'd1 || sq_sub == 2'd2) sq_sda = 1'b1;
			end
			SEG_READ: begin
				sq_sda = 1'b1;
				sq_scl = (sq_sub == 2'd1);
			end
			SEG_NACK: begin
				sq_scl = (sq_sub == 2'd2);
				if (sq_sub >= 2'd1) sq_sda = 1'b1;
			end
			SEG_STOP, SEG_STOP_ABT: begin
				sq_scl = (sq_sub >= 2'd2);
				if (sq_sub == 2'd1) sq_sda = 1'b0;
				if (sq_sub == 2'd3) sq_sda = 1'b1;
			end
			default: begin
				sq_scl = 1'b1;
				sq_sda = 1'b1;
			end
		endcase
	endfunction

	function automatic void enter_seg(input seg_t s);
		sq_seg = s;
		sq_sub = 2'd0;
		sq_bit = 3'd0;
		case (s)
			SEG_ADDR_W: sq_shift = {sq_addr, 1'b0};
			SEG_REG:    sq_shift = sq_reg;
			SEG_DATA:   sq_shift = sq_data;
			SEG_ADDR_R: sq_shift = {sq_addr, 1'b1};
			SEG_READ:   sq_shift = '0;
			default: ;
		endcase
		update_pins();
	endfunction

	function automatic void step_sub();
		sq_sub = sq_sub + 2'd1;
		update_pins();
	endfunction

	// end of a timing slot, returns 1 when the transfer is over
	function automatic bit finish_slot(input logic sda, output stat_t st);
		st = ST_OK;
		case (sq_seg)
			SEG_START1, SEG_START2: begin
				if (sq_seg == SEG_START1 && sq_sub == 2'd0 && !sda) begin
					st = ST_BUS_BUSY;
					return 1'b1;
				end
				if (sq_seg == SEG_START1 && sq_sub == 2'd1 && sda) begin
					st = ST_NO_START;
					return 1'b1;
				end
				if (sq_sub >= 2'd2) enter_seg(sq_seg == SEG_START1 ? SEG_ADDR_W : SEG_ADDR_R);
				else step_sub();
			end
			SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R: begin
				if (sq_sub < 2'd2) step_sub();
				else begin
					sq_shift = sq_shift << 1;
					if (sq_bit == 3'd7) enter_seg(seg_t'(sq_seg + 4'd1));
					else begin
						sq_bit = sq_bit + 3'd1;
						sq_sub = 2'd0;
						update_pins();
					end
				end
			end
			SEG_ACK_ADDR, SEG_ACK_REG, SEG_ACK_DATA, SEG_ACK_ADDRR: begin
				if (sq_sub == 2'd2) begin
					// only the address ack is remembered
					if (sq_seg == SEG_ACK_ADDR) sq_bit = {2'b00, sda};
					step_sub();
				end else if (sq_sub < 2'd3) step_sub();
				else begin
					case (sq_seg)
						SEG_ACK_ADDR: enter_seg(sq_bit != 3'd0 ? SEG_STOP_ABT : SEG_REG);
						SEG_ACK_REG:  enter_seg(sq_is_read ? SEG_START2 : SEG_DATA);
						SEG_ACK_DATA: enter_seg(SEG_STOP);
						default:      enter_seg(SEG_READ);
					endcase
				end
			end
			SEG_READ: begin
				if (sq_sub == 2'd0) step_sub();
				else begin
					sq_shift = {sq_shift[BYTE_W-2:0], sda};
					if (sq_bit == 3'd7) enter_seg(SEG_NACK);
					else begin
						sq_bit = sq_bit + 3'd1;
						sq_sub = 2'd0;
						update_pins();
					end
				end
			end
			SEG_NACK: begin
				if (sq_sub < 2'd3) step_sub();
				else enter_seg(SEG_STOP);
			end
			SEG_STOP: begin
				if (sq_sub < 2'd3) step_sub();
				else if (!sq_is_read && cfg_rec != '0) begin
					sq_rec = cfg_rec;
					enter_seg(SEG_RECOVERY);
				end else return 1'b1;
			end
			SEG_STOP_ABT: begin
				if (sq_sub < 2'd3) step_sub();
				else begin
					st = ST_NO_ACK;
					return 1'b1;
				end
			end
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic ira_res_t predict_bus(input ira_cmd_t c);
		ira_res_t r;
		bit       fin;
		stat_t    st;
		int       lim;
		fin = 1'b0;
		st  = ST_OK;
		r   = '0;
		if (sq_seg == SEG_IDLE) begin
			if (c.operation == OP_WRITE || c.operation == OP_READ) begin
				steps_taken++;
				sq_addr     = c.target_address;
				sq_reg      = c.register_index;
				sq_data     = c.write_data;
				sq_is_read  = (c.operation == OP_READ);
				sq_slot_cnt = '0;
				enter_seg(SEG_START1);
			end
		end else if (c.operation == OP_TICK) begin
			steps_taken++;
			if (sq_seg == SEG_RECOVERY) begin
				sq_rec = sq_rec - 16'd1;
				fin = (sq_rec == '0);
			end else begin
				lim = (cfg_slot == '0) ? 1 : int'(cfg_slot);
				if (int'(sq_slot_cnt) + 1 >= lim) begin
					sq_slot_cnt = '0;
					fin = finish_slot(c.sda_in, st);
				end else sq_slot_cnt = sq_slot_cnt + 8'd1;
			end
			if (fin) begin
				if (st == ST_OK && sq_is_read) r.rd = sq_shift;
				if (st != ST_OK) n_aborts++;
				else if (sq_is_read) n_reads++;
				else n_writes++;
				sq_seg      = SEG_IDLE;
				sq_sub      = 2'd0;
				sq_bit      = 3'd0;
				sq_slot_cnt = '0;
				sq_rec      = '0;
				sq_scl      = 1'b1;
				sq_sda      = 1'b1;
			end
		end
		r.scl    = sq_scl;
		r.sda    = sq_sda;
		r.busy   = (sq_seg != SEG_IDLE);
		r.done   = fin;
		r.status = fin ? st : ST_OK;
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] rg,
			input logic [BYTE_W-1:0] dat, input logic sda, input logic typed,
			input logic scl, input logic sdl, input logic busy, input logic done,
			input stat_t st);
		dir_row_t d;
		d.req         = '{op, addr, rg, dat, sda};
		d.typed       = typed;
		d.want.scl    = scl;
		d.want.sda    = sdl;
		d.want.busy   = busy;
		d.want.done   = done;
		d.want.status = st;
		d.want.rd     = '0;
		return d;
	endfunction

	function automatic ira_cmd_t rand_req();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(ira_cmd_t)-1:0];
	endfunction

	// what the device and the wire put on SDA for the current slot
	function automatic logic pick_sda(input fault_t f, input logic [BYTE_W-1:0] slave_byte);
		case (sq_seg)
			SEG_START1: begin
				if (sq_sub == 2'd0) return f != FLT_BUS_BUSY;
				if (sq_sub == 2'd1) return f == FLT_NO_START;
				return sq_sda;
			end
			SEG_ACK_ADDR: return f == FLT_NO_ACK;
			// later acks are not checked, so let them wander
			SEG_ACK_REG, SEG_ACK_DATA, SEG_ACK_ADDRR: return $urandom_range(0, 3) == 0;
			SEG_READ: return slave_byte[3'd7 - sq_bit];
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic send_req(input ira_cmd_t c, input bit typed, input ira_res_t want);
		int       gap;
		ira_res_t pred;
		gap = cmd_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.operation      <= c.operation;
		cmd_ch.target_address <= c.target_address;
		cmd_ch.register_index <= c.register_index;
		cmd_ch.write_data     <= c.write_data;
		cmd_ch.sda_in         <= c.sda_in;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pred = predict_bus(c);
		bus_expect_q.push_back(typed ? want : pred);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == REG_SLOT_TICKS) cfg_slot = val[SLOT_W-1:0];
		else cfg_rec = val;
	endtask

	task automatic set_timing(input logic [SLOT_W-1:0] slot, input logic [REC_W-1:0] rec);
		cmd_ch.valid <= 1'b0;
		while (bus_expect_q.size() != 0) @(posedge clk);
		write_reg(REG_SLOT_TICKS, CFG_DATA_W'(slot));
		write_reg(REG_RECOVERY, rec);
		cfg_ch.valid <= 1'b0;
	endtask

	// ticks until the sequencer is idle again, with the odd ignored command mixed in
	task automatic clock_out(input fault_t f);
		ira_cmd_t          c;
		logic [BYTE_W-1:0] slave_byte;
		slave_byte = BYTE_W'($urandom_range(0, 255));
		while (sq_seg != SEG_IDLE) begin
			c = rand_req();
			if ($urandom_range(0, 15) == 0) c.operation = OP_W'($urandom_range(1, 3));
			else begin
				c.operation = OP_TICK;
				c.sda_in    = pick_sda(f, slave_byte);
			end
			send_req(c, 1'b0, '0);
		end
	endtask

	task automatic run_transfer(input op_t op, input fault_t f);
		ira_cmd_t c;
		c = rand_req();
		c.operation = op;
		send_req(c, 1'b0, '0);
		clock_out(f);
	endtask

	task automatic random_phase(input int budget);
		int       stop_at;
		ira_cmd_t c;
		op_t      op;
		fault_t   f;
		stop_at = steps_taken + budget;
		while (steps_taken < stop_at) begin
			cmd_idle = $urandom_range(0, 3) != 0;
			res_idle = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(0, 2)) begin
				c = rand_req();
				c.operation = $urandom_range(0, 1) ? OP_TICK : OP_UNUSED;
				send_req(c, 1'b0, '0);
			end
			op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			case ($urandom_range(0, 7))
				0: f = FLT_BUS_BUSY;
				1: f = FLT_NO_START;
				2: f = FLT_NO_ACK;
				default: f = FLT_NONE;
			endcase
			run_transfer(op, f);
		end
	endtask

	// result side: check against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			res_gap = 0;
		end else begin : rx
			ira_res_t want;
			logic     bad;
			if (res_ch.valid && res_ch.ready) begin
				n_checked++;
				if (bus_expect_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result: scl %b sda %b busy %b done %b status %0d rd %02h",
							res_ch.scl_release, res_ch.sda_release, res_ch.busy_res,
							res_ch.done_res, res_ch.status, res_ch.read_data);
				end else begin
					want = bus_expect_q.pop_front();
					bad = (res_ch.scl_release !== want.scl) || (res_ch.sda_release !== want.sda) ||
						(res_ch.busy_res !== want.busy) || (res_ch.done_res !== want.done) ||
						(res_ch.status !== want.status) || (res_ch.read_data !== want.rd);
					if (bad) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch exp/act: scl %b/%b sda %b/%b busy %b/%b done %b/%b status %0d/%0d rd %02h/%02h",
								want.scl, res_ch.scl_release, want.sda, res_ch.sda_release,
								want.busy, res_ch.busy_res, want.done, res_ch.done_res,
								want.status, res_ch.status, want.rd, res_ch.read_data);
					end
				end
				res_gap = res_idle ? $urandom_range(0, 14) : 0;
			end
			if (res_gap != 0) begin
				res_gap--;
				res_ch.ready <= 1'b0;
			end else res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles", quiet_cycles);
			$display("[i2c_register_access_master_top] ERROR");
			$finish;
		end
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.operation      = OP_TICK;
		cmd_ch.target_address = '0;
		cmd_ch.register_index = '0;
		cmd_ch.write_data     = '0;
		cmd_ch.sda_in         = 1'b1;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_SLOT_TICKS;
		cfg_ch.data           = '0;
		res_ch.ready          = 1'b0;

		sq_seg      = SEG_IDLE;
		sq_sub      = 2'd0;
		sq_bit      = 3'd0;
		sq_shift    = '0;
		sq_slot_cnt = '0;
		sq_rec      = '0;
		sq_addr     = '0;
		sq_reg      = '0;
		sq_data     = '0;
		sq_is_read  = 1'b0;
		sq_scl      = 1'b1;
		sq_sda      = 1'b1;
		cfg_slot    = SLOT_TICKS_RST;
		cfg_rec     = RECOVERY_RST;

		// idle ticks, ignored requests and both failed start checks
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 1, 0, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_UNUSED, 7'd127, 8'd255, 8'd255, 1'b1, 1, 1, 1, 0, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_WRITE,  7'd127, 8'd255, 8'd255, 1'b1, 1, 1, 1, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_READ,   7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 1, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_UNUSED, 7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 1, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 1, 0, 1, ST_BUS_BUSY));
		dir_rows.push_back(dir_row(OP_READ,   7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 1, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 1, 1, 0, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 1, 1, 1, 0, 1, ST_NO_START));
		dir_rows.push_back(dir_row(OP_TICK,   7'd127, 8'd255, 8'd255, 1'b1, 1, 1, 1, 0, 0, ST_OK));
		// clean start, then into the address byte
		dir_rows.push_back(dir_row(OP_WRITE,  7'h55,  8'hAA,  8'h0F,  1'b0, 1, 1, 1, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 1, 1, 0, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b0, 1, 1, 0, 1, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b0, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(dir_row(OP_TICK,   7'd0,   8'd0,   8'd0,   1'b1, 0, 0, 0, 0, 0, ST_OK));

		cmd_idle = 1'b1;
		res_idle = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		// the device never answers the address, so the write aborts
		clock_out(FLT_NO_ACK);

		set_timing(8'd1, 16'd0);
		random_phase(90);
		set_timing(8'd0, 16'd2);
		random_phase(70);
		set_timing(8'd2, 16'd1);
		random_phase(70);

		cmd_ch.valid <= 1'b0;
		while (bus_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (bus_expect_q.size() != 0) errors += bus_expect_q.size();

		$display("%0d sequencer steps: %0d writes and %0d reads completed, %0d transfers aborted",
			steps_taken, n_writes, n_reads, n_aborts);
		$display("%0d results checked, %0d failures", n_checked, errors);
		if (errors == 0) $display("[i2c_register_access_master_top] OK");
		else $display("[i2c_register_access_master_top] ERROR");
		$finish;
	end

endmodule

// ===== i2c_register_access_master_top.f =====
rtl/ira_pkg.sv
rtl/ira_cmd_if.sv
rtl/ira_res_if.sv
rtl/ira_cfg_if.sv
rtl/ira_cfg_regs.sv
rtl/ira_seq.sv
rtl/i2c_register_access_master_top.sv
tb/tb_top.sv
